// File: sv/gcd_pkg.sv
// shared types, constants and elaboration-time functions for the great-circle distance block
package gcd_pkg;

  // payload types
  typedef logic signed [27:0] lat_t;
  typedef logic signed [28:0] lon_t;
  typedef logic [22:0]        dist_t;

  // reduced angle in 2^-20 degree, and the Q30 datapath word
  localparam int AW = 34;
  typedef logic signed [28:0]   deg_t;
  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [2*AW-1:0] prod_t;

  localparam int MAX_STEPS = 40;

  // pi in Q60 and pi/180 in Q40, split for two narrow multipliers
  localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint unsigned DEG2RAD_Q40 = ((PI_Q60 >> 20) + 64'd90) / 64'd180;
  localparam logic signed [18:0] DEG2RAD_HI = 19'(DEG2RAD_Q40 >> 17);
  localparam logic signed [17:0] DEG2RAD_LO = 18'(DEG2RAD_Q40 & 64'h1FFFF);

  // turns in 2^-20 degree
  localparam logic signed [30:0] FULL_TURN    = 31'sd377487360;
  localparam logic signed [30:0] HALF_TURN    = 31'sd188743680;
  localparam logic signed [30:0] QUARTER_TURN = 31'sd94371840;

  localparam logic [30:0]        ONE_Q30   = 31'h40000000;
  localparam logic signed [14:0] RADIUS_KM = 15'sd6371;
  localparam dist_t              DIST_MAX  = 23'd5124096;

  // atan(2^-i) in Q30, rounded to nearest
  localparam ang_t ATAN_TAB [MAX_STEPS] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128,
    34'sd64,        34'sd32,        34'sd16,        34'sd8,
    34'sd4,         34'sd2,         34'sd1,         34'sd1,
    34'sd0,         34'sd0,         34'sd0,         34'sd0,
    34'sd0,         34'sd0,         34'sd0,         34'sd0
  };

  // integer square root, rounded down (elaboration only)
  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned rem;
    longint unsigned res;
    longint unsigned bitv;
    rem  = v;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // CORDIC gain G of the rotation unit in Q30 for a given step count
  function automatic longint unsigned gain_root(int steps);
    longint unsigned p;
    p = 64'd1 << 60;
    for (int i = 0; i < MAX_STEPS; i++) begin
      if (i < steps && 2 * i < 64) begin
        p = p + (p >> (2 * i));
      end
    end
    return isqrt64(p);
  endfunction

endpackage

// File: sv/gcd_if.sv
// valid/ready channels for point pairs and distances
interface gcd_pts_if;
  import gcd_pkg::*;
  logic valid;
  logic ready;
  lat_t lat_a;
  lon_t lon_a;
  lat_t lat_b;
  lon_t lon_b;
  modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
  modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcd_dist_if;
  import gcd_pkg::*;
  logic  valid;
  logic  ready;
  dist_t distance_q8;
  modport source (output valid, distance_q8, input ready);
  modport sink (input valid, distance_q8, output ready);
endinterface

// File: sv/great_circle_distance.sv
// haversine great-circle distance pipeline, fixed point
// Usage: pts carries one pair of points (lat/lon in signed 2^-20 degree) per item;
// result returns one distance in unsigned 2^-8 km per item, in input order.
// Both channels are valid/ready; an item moves when valid and ready are high.
// Throughput: one item per cycle, no gaps between items, unless a stall holds it.
// Stages, in order: two input stages, the rotation CORDIC chain (a load stage
// plus one iteration per stage), five product stages, the 32-stage square-root
// chain (load plus one result bit per stage), the vectoring CORDIC chain (a
// load stage plus one iteration per stage) and two output stages.
// Stall: the whole pipeline advances when the output register is empty or
// taken; while result.ready is low with a result held, pts.ready is low and
// every stage holds its item, so nothing is lost or repeated.
// Reset: synchronous rst clears all valid bits; the pipeline is empty and
// ready at the first cycle after reset. No tables need filling.
module great_circle_distance #(
  parameter int CORDIC_STEPS = 24
) (
  input logic          clk,
  input logic          rst,
  gcd_pts_if.sink      pts,
  gcd_dist_if.source   result
);
  import gcd_pkg::*;

  localparam int              N         = CORDIC_STEPS;
  localparam int              SQ_STEPS  = 31;
  localparam longint unsigned GAIN_ROOT = gain_root(CORDIC_STEPS);
  localparam ang_t            INV_GAIN  =
    ang_t'(((64'd1 << 60) + (GAIN_ROOT >> 1)) / GAIN_ROOT);

  // fold an angle difference into [-180, 180) degrees
  function automatic deg_t reduce_turn(logic signed [30:0] d);
    logic signed [30:0] r;
    r = d;
    if (d >= HALF_TURN) begin
      r = d - FULL_TURN;
    end else if (d < -HALF_TURN) begin
      r = d + FULL_TURN;
    end
    return deg_t'(r);
  endfunction

  // round a Q60 product back to Q30, ties toward +inf
  function automatic ang_t rshr30(prod_t v);
    prod_t r;
    r = (v + prod_t'(64'd536870912)) >>> 30;
    return ang_t'(r);
  endfunction

  logic  adv;
  logic  out_valid;
  dist_t out_dist;

  // global advance: output slot free or being taken
  assign adv                = !out_valid || result.ready;
  assign pts.ready          = adv;
  assign result.valid       = out_valid;
  assign result.distance_q8 = out_dist;

  // stage 1: differences, turn reduction, latitude fold
  logic signed [30:0] dlat, dlon;
  logic signed [28:0] lat_mag [2];
  deg_t               ang_in [4];
  logic [1:0]         neg_in;

  always_comb begin
    dlat      = 31'(pts.lat_b) - 31'(pts.lat_a);
    dlon      = 31'(pts.lon_b) - 31'(pts.lon_a);
    ang_in[0] = reduce_turn(dlat);
    ang_in[1] = reduce_turn(dlon);
    // latitudes already lie within half a turn
    lat_mag[0] = 29'(pts.lat_a);
    lat_mag[1] = 29'(pts.lat_b);
    for (int j = 0; j < 2; j++) begin
      neg_in[j] = 1'b0;
      if (lat_mag[j] < 0) begin
        lat_mag[j] = -lat_mag[j];
      end
      if (31'(lat_mag[j]) > QUARTER_TURN) begin
        lat_mag[j] = 29'(HALF_TURN - 31'(lat_mag[j]));
        neg_in[j]  = 1'b1;
      end
      ang_in[j+2] = lat_mag[j];
    end
  end

  deg_t       s1_ang [4];
  logic [1:0] s1_neg;
  logic       s1_v;

  // stage 2: degrees to radians, two partial products each
  logic signed [47:0] s2_pph [4];
  logic signed [46:0] s2_ppl [4];
  logic [1:0]         s2_neg;
  logic               s2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (adv) begin
      s1_v <= pts.valid;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ang <= ang_in;
      s1_neg <= neg_in;
      for (int j = 0; j < 4; j++) begin
        s2_pph[j] <= s1_ang[j] * DEG2RAD_HI;
        s2_ppl[j] <= s1_ang[j] * DEG2RAD_LO;
      end
      s2_neg <= s1_neg;
    end
  end

  // combine partial products and round: half angles and latitudes
  logic signed [65:0] rad_sum [4];
  ang_t               z_in [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      rad_sum[j] = (66'(s2_pph[j]) <<< 17) + 66'(s2_ppl[j]);
      if (j < 2) begin
        z_in[j] = ang_t'((rad_sum[j] + 66'sd1073741824) >>> 31);
      end else begin
        z_in[j] = ang_t'((rad_sum[j] + 66'sd536870912) >>> 30);
      end
    end
  end

  // rotation CORDIC, four lanes, one iteration per stage
  ang_t       rot_x [N+1][4];
  ang_t       rot_y [N+1][4];
  ang_t       rot_z [N+1][4];
  logic [1:0] rot_neg [N+1];
  logic [N:0] rot_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_v <= '0;
    end else if (adv) begin
      rot_v <= {rot_v[N-1:0], s2_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        rot_x[0][j] <= INV_GAIN;
        rot_y[0][j] <= '0;
        rot_z[0][j] <= z_in[j];
      end
      rot_neg[0] <= s2_neg;
      for (int i = 0; i < N; i++) begin
        for (int j = 0; j < 4; j++) begin
          if (!rot_z[i][j][AW-1]) begin
            rot_x[i+1][j] <= rot_x[i][j] - (rot_y[i][j] >>> i);
            rot_y[i+1][j] <= rot_y[i][j] + (rot_x[i][j] >>> i);
            rot_z[i+1][j] <= rot_z[i][j] - ATAN_TAB[i];
          end else begin
            rot_x[i+1][j] <= rot_x[i][j] + (rot_y[i][j] >>> i);
            rot_y[i+1][j] <= rot_y[i][j] - (rot_x[i][j] >>> i);
            rot_z[i+1][j] <= rot_z[i][j] + ATAN_TAB[i];
          end
        end
        rot_neg[i+1] <= rot_neg[i];
      end
    end
  end

  // haversine term a: squares and cosine products, each product registered
  prod_t      p1_lat, p1_lon, p3_t, p5_t;
  ang_t       p1_ca, p1_cb;
  ang_t       p2_alat, p2_t, p2_ca, p2_cb;
  ang_t       p3_alat, p3_cb;
  ang_t       p4_alat, p4_t, p4_cb;
  ang_t       p5_alat;
  logic [4:0] p_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= '0;
    end else if (adv) begin
      p_v <= {p_v[3:0], rot_v[N]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_lat  <= rot_y[N][0] * rot_y[N][0];
      p1_lon  <= rot_y[N][1] * rot_y[N][1];
      p1_ca   <= rot_neg[N][0] ? -rot_x[N][2] : rot_x[N][2];
      p1_cb   <= rot_neg[N][1] ? -rot_x[N][3] : rot_x[N][3];
      p2_alat <= rshr30(p1_lat);
      p2_t    <= rshr30(p1_lon);
      p2_ca   <= p1_ca;
      p2_cb   <= p1_cb;
      p3_t    <= p2_t * p2_ca;
      p3_alat <= p2_alat;
      p3_cb   <= p2_cb;
      p4_t    <= rshr30(p3_t);
      p4_alat <= p3_alat;
      p4_cb   <= p3_cb;
      p5_t    <= p4_t * p4_cb;
      p5_alat <= p4_alat;
    end
  end

  // sum and clamp a to [0, 1]
  logic signed [AW:0] a_sum;
  logic [30:0]        a_q;

  always_comb begin
    a_sum = (AW+1)'(p5_alat) + (AW+1)'(rshr30(p5_t));
    if (a_sum < 0) begin
      a_q = '0;
    end else if (a_sum > (AW+1)'(ONE_Q30)) begin
      a_q = ONE_Q30;
    end else begin
      a_q = 31'(a_sum);
    end
  end

  // square roots of a and 1 - a, one result bit per stage
  logic [60:0]         sq_rem [SQ_STEPS+1][2];
  logic [61:0]         sq_res [SQ_STEPS+1][2];
  logic [SQ_STEPS:0]   sq_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= '0;
    end else if (adv) begin
      sq_v <= {sq_v[SQ_STEPS-1:0], p_v[4]};
    end
  end

  always_ff @(posedge clk) begin
    logic [61:0] trial;
    if (adv) begin
      sq_rem[0][0] <= {a_q, 30'd0};
      sq_rem[0][1] <= {31'(ONE_Q30 - a_q), 30'd0};
      sq_res[0][0] <= '0;
      sq_res[0][1] <= '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
        for (int j = 0; j < 2; j++) begin
          trial = sq_res[k][j] + (62'd1 << (60 - 2 * k));
          if (62'(sq_rem[k][j]) >= trial) begin
            sq_rem[k+1][j] <= 61'(62'(sq_rem[k][j]) - trial);
            sq_res[k+1][j] <= (sq_res[k][j] >> 1) + (62'd1 << (60 - 2 * k));
          end else begin
            sq_rem[k+1][j] <= sq_rem[k][j];
            sq_res[k+1][j] <= sq_res[k][j] >> 1;
          end
        end
      end
    end
  end

  // vectoring CORDIC: atan2(sqrt(a), sqrt(1 - a)) gives c/2
  ang_t       vec_x [N+1];
  ang_t       vec_y [N+1];
  ang_t       vec_z [N+1];
  logic [N:0] vec_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_v <= '0;
    end else if (adv) begin
      vec_v <= {vec_v[N-1:0], sq_v[SQ_STEPS]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec_x[0] <= ang_t'(sq_res[SQ_STEPS][1]);
      vec_y[0] <= ang_t'(sq_res[SQ_STEPS][0]);
      vec_z[0] <= '0;
      for (int i = 0; i < N; i++) begin
        if (!vec_y[i][AW-1]) begin
          vec_x[i+1] <= vec_x[i] + (vec_y[i] >>> i);
          vec_y[i+1] <= vec_y[i] - (vec_x[i] >>> i);
          vec_z[i+1] <= vec_z[i] + ATAN_TAB[i];
        end else begin
          vec_x[i+1] <= vec_x[i] - (vec_y[i] >>> i);
          vec_y[i+1] <= vec_y[i] + (vec_x[i] >>> i);
          vec_z[i+1] <= vec_z[i] - ATAN_TAB[i];
        end
      end
    end
  end

  // scale by the radius, round and clamp into the output register
  logic signed [AW+14:0] m_dist;
  logic                  m_v;
  logic signed [AW+14:0] d_round;
  dist_t                 d_clamp;

  always_comb begin
    d_round = (m_dist + (AW+15)'(64'sd1048576)) >>> 21;
    if (d_round < 0) begin
      d_clamp = '0;
    end else if (d_round > (AW+15)'(DIST_MAX)) begin
      d_clamp = DIST_MAX;
    end else begin
      d_clamp = dist_t'(d_round);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      m_v       <= vec_v[N];
      out_valid <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_dist   <= vec_z[N] * RADIUS_KM;
      out_dist <= d_clamp;
    end
  end

endmodule
